>>> hdl/pid_antiwindup_derivative_on_measurement_top_assert.svh
// Assertion macros for the PID controller block.
// Each macro expects aclk and aresetn in scope.
`ifndef PID_ANTIWINDUP_DERIVATIVE_ON_MEASUREMENT_TOP_ASSERT_SVH
`define PID_ANTIWINDUP_DERIVATIVE_ON_MEASUREMENT_TOP_ASSERT_SVH

// Same-cycle implication.
`define PIDAWD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pid controller check failed");

// Next-cycle implication.
`define PIDAWD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pid controller check failed");

`endif

>>> hdl/pidawd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pidawd_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int GAIN_W     = 32;
    localparam int SAMPLE_W   = 32;
    localparam int INTEG_W    = 48;
    localparam int DRIVE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int S_TDATA_W  = 112;  // target, measured, preload_value
    localparam int M_TDATA_W  = 24;   // drive, saturation, zero pad

    localparam logic [INTEG_W-1:0] UPPER_LIMIT_RST = 48'd4294901760;  // 65535.0
    localparam logic [DRIVE_W-1:0] DRIVE_MAX       = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_COMPUTE = 2'd0,
        OP_PRELOAD = 2'd1,
        OP_CLEAR   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        SAT_NONE = 2'd0,
        SAT_HIGH = 2'd1,
        SAT_LOW  = 2'd2
    } sat_t;

    localparam logic [CFG_IDX_W-1:0] CFG_KP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_DT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_DT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 3'd4;

endpackage

`default_nettype wire

>>> hdl/pid_antiwindup_derivative_on_measurement_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Fields (low bit first)                              Transaction when
// s_*       in   tdata: target[31:0] measured[63:32] preload[111:64]  s_tvalid & s_tready
//                tuser: operation[1:0]
// m_*       out  tdata: drive[15:0] saturation[17:16] pad[23:18]      m_tvalid & m_tready
// cfg_*     in   cfg_index[2:0], cfg_data[47:0]                      cfg_valid & cfg_ready
//
// One transaction per cycle sustained while m_tready is high; each result passes the stages below.
// Stages: input/error register, multiplier register (three 32x33 products),
// then the state/result register where integral, drive and saturation update.
// Reset (aresetn low, synchronous) clears gains, lower limit and controller state; upper limit -> 65535.0.
// A stalled m side fills the pipeline bubbles first, then drops s_tready.
// cfg_ready is always high; configuration must be written only while idle, which the block does not enforce.

module pid_antiwindup_derivative_on_measurement_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input item
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    input  wire logic [pidawd_pkg::S_TDATA_W-1:0]  s_tdata,  // target, measured, preload_value
    input  wire logic [1:0]                        s_tuser,  // operation
    // result item
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    output      logic [pidawd_pkg::M_TDATA_W-1:0]  m_tdata,  // drive, saturation, zero pad
    // configuration writes
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [pidawd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pidawd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pidawd_pkg::*;

    localparam int ERR_W  = SAMPLE_W + 1;        // exact difference of two samples
    localparam int PROD_W = GAIN_W + ERR_W;      // exact product
    localparam int TERM_W = PROD_W - FRAC_BITS;  // product shifted back to Q.16
    localparam int ISUM_W = TERM_W + 1;
    localparam int TOT_W  = ISUM_W + 1;
    localparam logic signed [TOT_W-1:0] SUM_MAX = TOT_W'(65535) <<< FRAC_BITS;

    // ---------------- configuration registers ----------------
    logic signed [GAIN_W-1:0]  kp_reg, ki_reg, kd_reg;
    logic signed [INTEG_W-1:0] upper_reg, lower_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg    <= '0;
            ki_reg    <= '0;
            kd_reg    <= '0;
            upper_reg <= UPPER_LIMIT_RST;
            lower_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_KP:    kp_reg    <= cfg_data[GAIN_W-1:0];
                CFG_KI_DT: ki_reg    <= cfg_data[GAIN_W-1:0];
                CFG_KD_DT: kd_reg    <= cfg_data[GAIN_W-1:0];
                CFG_UPPER: upper_reg <= cfg_data[INTEG_W-1:0];
                CFG_LOWER: lower_reg <= cfg_data[INTEG_W-1:0];
                default: ;  // unmapped index: write is dropped
            endcase
        end
    end

    // ---------------- pipeline flow ----------------
    logic v1_reg, v2_reg, m_tvalid_reg;
    logic load3, load2;

    assign load3    = !m_tvalid_reg || m_tready;  // output slot free
    assign load2    = !v2_reg || (v2_reg && load3);
    assign s_tready = !v1_reg || load2;
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_tready) v1_reg <= s_tvalid;
            if (load2)    v2_reg <= v1_reg;
            if (load3)    m_tvalid_reg <= v2_reg;
        end
    end

    // ---------------- stage 1: errors ----------------
    logic signed [SAMPLE_W-1:0] in_target, in_measured;
    logic signed [SAMPLE_W-1:0] prev_meas_reg;
    op_t                        in_op;
    logic                       s_fire;

    assign in_target   = s_tdata[SAMPLE_W-1:0];
    assign in_measured = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
    assign in_op       = op_t'(s_tuser);
    assign s_fire      = s_tvalid && s_tready;

    // Last feedback is tracked in input order so the difference is ready at entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_meas_reg <= '0;
        end else if (s_fire) begin
            case (in_op)
                OP_COMPUTE: prev_meas_reg <= in_measured;
                OP_CLEAR:   prev_meas_reg <= '0;
                default: ;
            endcase
        end
    end

    op_t                       op1_reg;
    logic signed [ERR_W-1:0]   err1_reg;
    logic signed [ERR_W-1:0]   dneg1_reg;  // previous - measured, sign folded in
    logic signed [INTEG_W-1:0] pre1_reg;

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            op1_reg   <= in_op;
            err1_reg  <= ERR_W'(in_target) - ERR_W'(in_measured);
            dneg1_reg <= ERR_W'(prev_meas_reg) - ERR_W'(in_measured);
            pre1_reg  <= s_tdata[2*SAMPLE_W+INTEG_W-1:2*SAMPLE_W];
        end
    end

    // ---------------- stage 2: products ----------------
    logic signed [PROD_W-1:0] prod_p, prod_i, prod_d;

    assign prod_p = PROD_W'(kp_reg) * PROD_W'(err1_reg);
    assign prod_i = PROD_W'(ki_reg) * PROD_W'(err1_reg);
    assign prod_d = PROD_W'(kd_reg) * PROD_W'(dneg1_reg);

    op_t                       op2_reg;
    logic                      errpos2_reg, errneg2_reg;
    logic signed [TERM_W-1:0]  p2_reg, i2_reg, d2_reg;
    logic signed [INTEG_W-1:0] pre2_reg;

    always_ff @(posedge aclk) begin
        if (load2) begin
            op2_reg     <= op1_reg;
            errpos2_reg <= !err1_reg[ERR_W-1] && (err1_reg != '0);
            errneg2_reg <= err1_reg[ERR_W-1];
            // arithmetic shift right by the fraction width (floor)
            p2_reg      <= prod_p[PROD_W-1:FRAC_BITS];
            i2_reg      <= prod_i[PROD_W-1:FRAC_BITS];
            d2_reg      <= prod_d[PROD_W-1:FRAC_BITS];
            pre2_reg    <= pre1_reg;
        end
    end

    // ---------------- stage 3: state and result ----------------
    logic signed [INTEG_W-1:0] acc_reg;
    logic [DRIVE_W-1:0]        drive_reg;
    sat_t                      sat_reg;

    function automatic logic signed [INTEG_W-1:0] clamp_int(
        input logic signed [ISUM_W-1:0]  v,
        input logic signed [INTEG_W-1:0] hi,
        input logic signed [INTEG_W-1:0] lo
    );
        logic signed [INTEG_W-1:0] r;
        if (v > ISUM_W'(hi))      r = hi;
        else if (v < ISUM_W'(lo)) r = lo;
        else                      r = v[INTEG_W-1:0];
        return r;
    endfunction

    logic                      freeze;
    logic signed [ISUM_W-1:0]  int_sum, pd_sum;
    logic signed [INTEG_W-1:0] int_comp, int_pre;
    logic signed [TOT_W-1:0]   total;

    // Conditional integration: hold the integral while pushing further into saturation.
    assign freeze   = (sat_reg == SAT_HIGH && errpos2_reg) ||
                      (sat_reg == SAT_LOW && errneg2_reg);
    assign int_sum  = ISUM_W'(acc_reg) + ISUM_W'(i2_reg);
    assign int_comp = freeze ? acc_reg : clamp_int(int_sum, upper_reg, lower_reg);
    assign int_pre  = clamp_int(ISUM_W'(pre2_reg), upper_reg, lower_reg);
    assign pd_sum   = ISUM_W'(p2_reg) + ISUM_W'(d2_reg);
    assign total    = TOT_W'(pd_sum) + TOT_W'(int_comp);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            drive_reg <= '0;
            sat_reg   <= SAT_NONE;
        end else if (load3 && v2_reg) begin
            case (op2_reg)
                OP_COMPUTE: begin
                    acc_reg <= int_comp;
                    if (total > SUM_MAX) begin
                        drive_reg <= DRIVE_MAX;
                        sat_reg   <= SAT_HIGH;
                    end else if (total[TOT_W-1]) begin
                        drive_reg <= '0;
                        sat_reg   <= SAT_LOW;
                    end else begin
                        drive_reg <= total[FRAC_BITS+DRIVE_W-1:FRAC_BITS];
                        sat_reg   <= SAT_NONE;
                    end
                end
                OP_PRELOAD: acc_reg <= int_pre;
                OP_CLEAR: begin
                    acc_reg   <= '0;
                    drive_reg <= '0;
                    sat_reg   <= SAT_NONE;
                end
                default: ;  // unused code: state held, result repeats it
            endcase
        end
    end

    assign m_tdata = {(M_TDATA_W - DRIVE_W - 2)'(0), sat_reg, drive_reg};

    // ---------------- checks ----------------
`include "pid_antiwindup_derivative_on_measurement_top_assert.svh"

    `PIDAWD_ASSERT_IMP(a_high_means_max, m_tvalid && sat_reg == SAT_HIGH, drive_reg == DRIVE_MAX)
    `PIDAWD_ASSERT_IMP(a_empty_out_ready, !m_tvalid_reg, s_tready)
    `PIDAWD_ASSERT_NEXT(a_clear_result, load3 && v2_reg && op2_reg == OP_CLEAR, m_tdata == '0)

endmodule

`default_nettype wire
